[design/cdq_pkg.sv]
// Shared types, codes and index helpers for the circular deque.
// Used by circular_deque and cdq_checker; depends on nothing else.
package cdq_pkg;

   // Number of slots in the store; one is always kept free
   localparam int DEPTH   = 16;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DATA_W  = 32;
   localparam int MODE_W  = 3;
   localparam int STAT_W  = 2;

   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_REAR  = 3'd0,
      MODE_PUSH_FRONT = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_REAR   = 3'd3,
      MODE_PEEK_FRONT = 3'd4,
      MODE_PEEK_REAR  = 3'd5
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   // Result attributes that travel with an item between stages
   typedef struct packed {
      logic       is_full_now;
      logic       is_empty_now;
      status_type status;
      logic       use_read;
   } meta_type;

   // Advance an index by one slot, wrapping at the end of the store
   function automatic idx_type wrap_inc(input idx_type i);
      return (i == idx_type'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   // Step an index back by one slot, wrapping at the start of the store
   function automatic idx_type wrap_dec(input idx_type i);
      return (i == '0) ? idx_type'(DEPTH - 1) : i - 1'b1;
   endfunction

endpackage

[design/cdq_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
// Generic; no package dependency.
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/circular_deque.sv]
// Circular deque top level: operation decode, index registers, result stages.
// Depends on cdq_pkg and cdq_ram.
//
// Usage:
//   Each transfer on the req_ channel carries one operation (req_tuser) and a
//   push value (req_tdata). Each operation yields exactly one transfer on the
//   rsp_ channel: the popped or peeked value in rsp_tdata, and the status and
//   the empty and full flags after the operation in rsp_tuser.
//   A push when full or a pop or peek when empty is rejected: the state holds
//   and the status says why. Unused operation codes change nothing.
// Timing:
//   One operation is accepted every cycle unless a stall holds req_tready low.
//   The result passes through the registered read of the slot memory and then
//   the output register before it is presented.
//   Indices update at acceptance, so a read issued in the cycle after a write
//   to the same slot already sees the new value.
// Stalls:
//   A result waits in the output register while rsp_tready is low; one more
//   operation is taken into the read stage, after which req_tready drops.
// Reset:
//   Both indices clear (deque empty) and both stages empty. The slots are not
//   cleared; only slots written by a push are ever read.
module circular_deque (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] push_value
   input  logic [2:0]  req_tuser,   // [2:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] read_value
   output logic [3:0]  rsp_tuser    // [1:0] status, [2] is_empty_now, [3] is_full_now
);

   cdq_pkg::idx_type  front_ff, front_in, front_nxt;
   cdq_pkg::idx_type  rear_ff, rear_in, rear_nxt;
   cdq_pkg::idx_type  wr_addr, rd_addr;
   cdq_pkg::mode_type mode;
   cdq_pkg::meta_type meta_nxt;
   cdq_pkg::meta_type s1_meta_ff, s1_meta_in;
   cdq_pkg::meta_type rsp_meta_ff, rsp_meta_in;
   logic              s1_valid_ff, s1_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;
   logic [31:0]       rd_data;
   logic              accept, advance;
   logic              none_held, is_full;
   logic              wr_op, rd_op;

   assign mode      = cdq_pkg::mode_type'(req_tuser);
   assign none_held = (front_ff == rear_ff);
   assign is_full   = (cdq_pkg::wrap_inc(rear_ff) == front_ff);

   // Move the read stage forward when the output register is free or drains
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   // Decode the operation: next indices, memory access and status
   always_comb begin
      front_nxt       = front_ff;
      rear_nxt        = rear_ff;
      wr_op           = 1'b0;
      wr_addr         = rear_ff;
      rd_op           = 1'b0;
      rd_addr         = rear_ff;
      meta_nxt.status = cdq_pkg::STAT_DONE;
      case (mode)
         cdq_pkg::MODE_PUSH_REAR: begin
            if (is_full) begin
               meta_nxt.status = cdq_pkg::STAT_FULL;
            end else begin
               rear_nxt = cdq_pkg::wrap_inc(rear_ff);
               wr_addr  = cdq_pkg::wrap_inc(rear_ff);
               wr_op    = 1'b1;
            end
         end
         cdq_pkg::MODE_PUSH_FRONT: begin
            if (is_full) begin
               meta_nxt.status = cdq_pkg::STAT_FULL;
            end else begin
               wr_addr   = front_ff;
               front_nxt = cdq_pkg::wrap_dec(front_ff);
               wr_op     = 1'b1;
            end
         end
         cdq_pkg::MODE_POP_FRONT: begin
            if (none_held) begin
               meta_nxt.status = cdq_pkg::STAT_EMPTY;
            end else begin
               front_nxt = cdq_pkg::wrap_inc(front_ff);
               rd_addr   = cdq_pkg::wrap_inc(front_ff);
               rd_op     = 1'b1;
            end
         end
         cdq_pkg::MODE_POP_REAR: begin
            if (none_held) begin
               meta_nxt.status = cdq_pkg::STAT_EMPTY;
            end else begin
               rd_addr  = rear_ff;
               rear_nxt = cdq_pkg::wrap_dec(rear_ff);
               rd_op    = 1'b1;
            end
         end
         cdq_pkg::MODE_PEEK_FRONT: begin
            if (none_held) begin
               meta_nxt.status = cdq_pkg::STAT_EMPTY;
            end else begin
               rd_addr = cdq_pkg::wrap_inc(front_ff);
               rd_op   = 1'b1;
            end
         end
         cdq_pkg::MODE_PEEK_REAR: begin
            if (none_held) begin
               meta_nxt.status = cdq_pkg::STAT_EMPTY;
            end else begin
               rd_addr = rear_ff;
               rd_op   = 1'b1;
            end
         end
         default: begin
            // Unused codes leave the state alone
         end
      endcase
      meta_nxt.use_read     = rd_op;
      meta_nxt.is_empty_now = (front_nxt == rear_nxt);
      meta_nxt.is_full_now  = (cdq_pkg::wrap_inc(rear_nxt) == front_nxt);
   end

   // Commit the indices only on an accepted transfer
   assign front_in = accept ? front_nxt : front_ff;
   assign rear_in  = accept ? rear_nxt  : rear_ff;

   cdq_ram #(
      .WIDTH (cdq_pkg::DATA_W),
      .DEPTH (cdq_pkg::DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (accept && wr_op),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (accept && rd_op),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next values of the read stage and the output register
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_meta_in   = s1_meta_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_meta_in  = rsp_meta_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         s1_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_meta_in  = s1_meta_ff;
         rsp_data_in  = s1_meta_ff.use_read ? rd_data : '0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_meta_in  = meta_nxt;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         rear_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_meta_ff  <= s1_meta_in;
      rsp_meta_ff <= rsp_meta_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_meta_ff.is_full_now, rsp_meta_ff.is_empty_now,
                        rsp_meta_ff.status};

endmodule

[design/cdq_checker.sv]
// Port-level checks for circular_deque, attached by the bind below.
// Depends on cdq_pkg.
module cdq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   else $error("stalled result changed");

   // The deque is never empty and full at once
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[2] && rsp_tuser[3]))
   else $error("empty and full together");

   // A push rejected for fullness leaves the deque full, with zero data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == cdq_pkg::STAT_FULL |-> rsp_tuser[3] && rsp_tdata == '0)
   else $error("full rejection inconsistent");

   // A read rejected for emptiness leaves the deque empty, with zero data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == cdq_pkg::STAT_EMPTY |-> rsp_tuser[2] && rsp_tdata == '0)
   else $error("empty rejection inconsistent");

   // No result appears in the cycle after reset
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
   else $error("result after reset");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
